/* design/rplp_pkg.sv */
// ----------------------------------------------------------------------------
// rplp_pkg
// Shared types and character constants for the radix-prefixed literal parser.
// ----------------------------------------------------------------------------
package rplp_pkg;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_1      = 8'h31;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_B   = 8'h42;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_UC_O   = 8'h4F;
	localparam logic [7:0] CH_UC_X   = 8'h58;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_O   = 8'h6F;
	localparam logic [7:0] CH_LC_X   = 8'h78;

	localparam logic [3:0] LETTER_OFFSET = 4'd9;

	typedef enum logic [1:0] {
		RK_DEC = 2'd0,
		RK_HEX = 2'd1,
		RK_OCT = 2'd2,
		RK_BIN = 2'd3
	} radix_t;

	// Decoded view of one input character.
	typedef struct packed {
		logic       is_white;
		logic       is_dollar;
		logic       is_bin_pfx;
		logic       is_under;
		logic       is_zero;
		logic       is_x;
		logic       is_o;
		logic       is_b;
		logic       dec_ok;
		logic       oct_ok;
		logic       bin_ok;
		logic       hex_ok;
		logic [3:0] digit;
	} char_class_t;

	typedef struct packed {
		logic [63:0] value;
		logic [7:0]  count;
		radix_t      kind;
	} result_t;

endpackage

/* design/radix_prefixed_literal_parser.sv */
// ----------------------------------------------------------------------------
// radix_prefixed_literal_parser
// Converts a character stream holding unsigned numeric literals ($, @, %,
// 0x, 0o, 0b prefixes, plain octal, plain decimal) into 64-bit values.
//
//   channel | signals                          | direction | payload
//   --------+----------------------------------+-----------+-----------------
//   in      | in_valid, in_stall               | into      | char_in
//   out     | out_valid, out_stall             | out of    | literal_value,
//           |                                  |           | chars_used,
//           |                                  |           | radix_kind
//
// One character per cycle while in_stall is low. A character is decoded into
// the input register and steps the parser state as it leaves that register; a
// terminator loads the result register at that edge, which then offers it.
// A terminator waits in the input register only while the result register is
// full and out_stall is high; a result taken in the same cycle makes room.
// Reset clears all control state and the parser to idle; no clearing pass.
// ----------------------------------------------------------------------------
module radix_prefixed_literal_parser import rplp_pkg::*; #(
	parameter int unsigned MAX_COUNT = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] literal_value,
	output logic [7:0]  chars_used,
	output logic [1:0]  radix_kind
);

	char_class_t cls_in;
	char_class_t cls_s1;
	logic        valid_s1;
	logic        step;
	logic        emit;
	logic        in_take;
	result_t     res;
	logic        out_valid_q;
	result_t     res_q;

	rplp_char_class u_class (
		.char_in (char_in),
		.cls     (cls_in)
	);

	rplp_core #(
		.MAX_COUNT (MAX_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cls    (cls_s1),
		.emit   (emit),
		.res    (res)
	);

	// hold a terminator while the previous result is still stalled in the output
	assign step     = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cls_s1 <= cls_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign literal_value = res_q.value;
	assign chars_used    = res_q.count;
	assign radix_kind    = res_q.kind;

	localparam logic [7:0] CountCap = (MAX_COUNT < 255) ? 8'(MAX_COUNT) : 8'd255;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while full");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && emit && out_valid_q && out_stall))
		else $error("input stalled without a blocked terminator");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step && emit))
		else $error("result appeared without a terminator step");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.count <= CountCap))
		else $error("character count above its limit");

endmodule

/* design/rplp_char_class.sv */
// ----------------------------------------------------------------------------
// rplp_char_class
// Decodes one ASCII byte into the classes the parser steps on.
// ----------------------------------------------------------------------------
module rplp_char_class import rplp_pkg::*; (
	input  logic [7:0]  char_in,
	output char_class_t cls
);

	logic is_dec;
	logic is_lc_hex;
	logic is_uc_hex;

	always_comb begin
		is_dec    = (char_in >= CH_0) && (char_in <= CH_9);
		is_lc_hex = (char_in >= CH_LC_A) && (char_in <= CH_LC_F);
		is_uc_hex = (char_in >= CH_UC_A) && (char_in <= CH_UC_F);

		cls.is_white   = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
		cls.is_dollar  = (char_in == CH_DOLLAR);
		cls.is_bin_pfx = (char_in == CH_AT) || (char_in == CH_PCT);
		cls.is_under   = (char_in == CH_UNDER);
		cls.is_zero    = (char_in == CH_0);
		cls.is_x       = (char_in == CH_LC_X) || (char_in == CH_UC_X);
		cls.is_o       = (char_in == CH_LC_O) || (char_in == CH_UC_O);
		cls.is_b       = (char_in == CH_LC_B) || (char_in == CH_UC_B);
		cls.dec_ok     = is_dec;
		cls.oct_ok     = (char_in >= CH_0) && (char_in <= CH_7);
		cls.bin_ok     = (char_in == CH_0) || (char_in == CH_1);
		cls.hex_ok     = is_dec || is_lc_hex || is_uc_hex;
		// letters a-f and A-F carry 1..6 in the low nibble
		cls.digit      = is_dec ? char_in[3:0] : (char_in[3:0] + LETTER_OFFSET);
	end

endmodule

/* design/rplp_core.sv */
// ----------------------------------------------------------------------------
// rplp_core
// Parser state machine: phase, accumulator and character count, one step
// per decoded character, with the finished literal offered combinationally.
// ----------------------------------------------------------------------------
module rplp_core import rplp_pkg::*; #(
	parameter int unsigned MAX_COUNT = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  char_class_t cls,
	output logic        emit,
	output result_t     res
);

	localparam logic [7:0] CountLimit = (MAX_COUNT < 255) ? 8'(MAX_COUNT) : 8'd255;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ZERO = 3'd1,
		PH_DEC  = 3'd2,
		PH_HEX  = 3'd3,
		PH_OCTP = 3'd4,
		PH_OCT  = 3'd5,
		PH_BIN  = 3'd6
	} phase_t;

	phase_t      phase_q;
	phase_t      phase_nxt;
	logic [63:0] acc_q;
	logic [63:0] acc_nxt;
	logic [7:0]  cnt_q;
	logic [7:0]  cnt_bumped;
	logic [63:0] digit_ext;
	logic [63:0] acc_dec;
	logic [63:0] acc_hex;
	logic [63:0] acc_oct;
	logic [63:0] acc_bin;
	logic        take;
	logic        wipe;
	radix_t      kind;

	always_comb begin
		digit_ext  = {60'd0, cls.digit};
		// times ten as x8 + x2
		acc_dec    = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + digit_ext;
		acc_hex    = {acc_q[59:0], cls.digit};
		acc_oct    = {acc_q[60:0], cls.digit[2:0]};
		acc_bin    = {acc_q[62:0], cls.digit[0]};
		cnt_bumped = (cnt_q < CountLimit) ? (cnt_q + 8'd1) : cnt_q;

		phase_nxt = phase_q;
		acc_nxt   = acc_q;
		take      = 1'b1;
		emit      = 1'b0;
		wipe      = 1'b0;
		kind      = RK_DEC;

		case (phase_q)
			PH_IDLE: begin
				if (cls.is_white) begin
					take = 1'b1;
				end else if (cls.is_dollar) begin
					phase_nxt = PH_HEX;
				end else if (cls.is_bin_pfx) begin
					phase_nxt = PH_BIN;
				end else if (cls.is_zero) begin
					phase_nxt = PH_ZERO;
				end else if (cls.dec_ok) begin
					phase_nxt = PH_DEC;
					acc_nxt   = digit_ext;
				end else begin
					emit = 1'b1;
				end
			end
			PH_ZERO: begin
				kind = RK_OCT;
				if (cls.is_x) begin
					phase_nxt = PH_HEX;
				end else if (cls.is_o) begin
					phase_nxt = PH_OCTP;
				end else if (cls.is_b) begin
					phase_nxt = PH_BIN;
				end else if (cls.oct_ok) begin
					phase_nxt = PH_OCT;
					acc_nxt   = digit_ext;
				end else begin
					emit = 1'b1;
				end
			end
			PH_DEC: begin
				if (cls.dec_ok) begin
					acc_nxt = acc_dec;
				end else begin
					emit = 1'b1;
				end
			end
			PH_HEX: begin
				kind = RK_HEX;
				if (cls.hex_ok) begin
					acc_nxt = acc_hex;
				end else if (!cls.is_under) begin
					emit = 1'b1;
				end
			end
			PH_OCTP: begin
				kind = RK_OCT;
				if (cls.oct_ok) begin
					acc_nxt = acc_oct;
				end else if (!cls.is_under) begin
					emit = 1'b1;
				end
			end
			PH_OCT: begin
				kind = RK_OCT;
				if (cls.oct_ok) begin
					acc_nxt = acc_oct;
				end else begin
					emit = 1'b1;
				end
			end
			PH_BIN: begin
				kind = RK_BIN;
				if (cls.bin_ok) begin
					acc_nxt = acc_bin;
				end else if (!cls.is_under) begin
					emit = 1'b1;
				end
			end
			default: begin
				// unused phase code: drop back to idle silently
				take = 1'b0;
				wipe = 1'b1;
			end
		endcase

		res.value = acc_q;
		res.count = cnt_q;
		res.kind  = kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= 64'd0;
			cnt_q   <= 8'd0;
		end else if (step) begin
			if (emit || wipe) begin
				phase_q <= PH_IDLE;
				acc_q   <= 64'd0;
				cnt_q   <= 8'd0;
			end else begin
				phase_q <= phase_nxt;
				acc_q   <= acc_nxt;
				if (take) begin
					cnt_q <= cnt_bumped;
				end
			end
		end
	end

endmodule
